// File: rtl/gbrm_pkg.sv
package gbrm_pkg;

	// mask storage
	localparam int unsigned WORD_BITS = 64;
	localparam int unsigned BIT_W = 6;
	localparam int unsigned MAX_CELLS_DEF = 262144;

	// grid geometry
	localparam int unsigned FLAT_W = 18;
	localparam int unsigned WIDX_W = FLAT_W - BIT_W;
	localparam int unsigned FREQ_W = 10;
	localparam int unsigned ACCEL_W = 8;
	localparam int unsigned FREQ_CFG_W = 11;
	localparam int unsigned ACCEL_CFG_W = 9;
	localparam int unsigned FREQ_MAX = 1024;
	localparam int unsigned ACCEL_MAX = 256;
	localparam int unsigned NCELLS_W = 19;

	// counters
	localparam int unsigned MARKED_W = 19;
	localparam int unsigned WINDOW_W = 16;

	// channels
	localparam int unsigned CMD_W = 2;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned CFG_DATA_W = 11;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_MARK  = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FREQ_CELLS  = 1'b0,
		CFG_ACCEL_CELLS = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLR,
		ST_MSETUP,
		ST_MROW,
		ST_MSPAN,
		ST_MRD,
		ST_MWR,
		ST_QRES,
		ST_RESP
	} state_t;

endpackage

// File: rtl/gbrm_if.sv
interface gbrm_req_if;
	logic                                valid;
	logic                                ready;
	logic [gbrm_pkg::CMD_W-1:0]          cmd;
	logic [gbrm_pkg::FREQ_W-1:0]         freq_lo;
	logic [gbrm_pkg::FREQ_W-1:0]         freq_hi;
	logic [gbrm_pkg::ACCEL_W-1:0]        accel_lo;
	logic [gbrm_pkg::ACCEL_W-1:0]        accel_hi;
	logic [gbrm_pkg::FLAT_W-1:0]         query_cell;

	modport source (output valid, cmd, freq_lo, freq_hi, accel_lo, accel_hi, query_cell,
		input ready);
	modport sink (input valid, cmd, freq_lo, freq_hi, accel_lo, accel_hi, query_cell,
		output ready);
endinterface

interface gbrm_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                keep;
	logic [gbrm_pkg::MARKED_W-1:0]       cells_marked;
	logic [gbrm_pkg::WINDOW_W-1:0]       windows_added;

	modport source (output valid, keep, cells_marked, windows_added, input ready);
	modport sink (input valid, keep, cells_marked, windows_added, output ready);
endinterface

interface gbrm_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [gbrm_pkg::CFG_IDX_W-1:0]      index;
	logic [gbrm_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/grid_bitmap_rectangle_mask.sv
// Grid bitmap rectangle mask: one bit per cell over an accel x freq grid, held
// in a single 64-bit wide synchronous RAM (MAX_CELLS/64 words).
// Channels: req (command beats: clear, mark rectangle, query cell), rsp (one
// result beat per command: keep flag plus both counters), cfg (register writes,
// always ready; only to be written while the block is idle).
// Command sequences, set by the single RAM port pair and the sequencer:
//   query : RAM read on acceptance, answer formed from the registered word in ST_QRES.
//   clear : one RAM word zeroed per cycle, then the result.
//   mark  : a setup step, then per row ST_MROW and ST_MSPAN and per word a
//           read-modify-write (ST_MRD, then ST_MWR).
//   cmd 3 : counters only.
// Reset: config returns to 1024 x 256, counters to zero, then a clearing pass
// zeroes all NWORDS words (4096 at the default MAX_CELLS) of the RAM; req.ready
// stays low for its length. cfg writes are taken during the pass.
// The result register parts the two sides: a new command is taken while the
// previous result still waits; a finished command whose result finds that
// register full holds in its last state until rsp.ready frees it.
module grid_bitmap_rectangle_mask #(
	parameter int unsigned MAX_CELLS = gbrm_pkg::MAX_CELLS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	gbrm_cfg_if.sink  cfg,
	gbrm_req_if.sink  req,
	gbrm_rsp_if.source rsp
);

	localparam int unsigned WB = gbrm_pkg::WORD_BITS;
	localparam int unsigned BW = gbrm_pkg::BIT_W;
	localparam int unsigned FW = gbrm_pkg::FLAT_W;
	localparam int unsigned NWORDS = (MAX_CELLS + WB - 1) / WB;
	localparam int unsigned AW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

	// ---------------------------------------------------------------- config
	logic [gbrm_pkg::FREQ_CFG_W-1:0]  freq_cfg_q, eff_f_c, eff_f_q;
	logic [gbrm_pkg::ACCEL_CFG_W-1:0] accel_cfg_q, eff_a_c, eff_a_q;
	logic [gbrm_pkg::NCELLS_W-1:0]    ncells_q;

	assign cfg.ready = 1'b1;

	// zero acts as one, oversize clamps to the grid maximum
	always_comb begin
		if (freq_cfg_q == '0)
			eff_f_c = gbrm_pkg::FREQ_CFG_W'(1);
		else if (freq_cfg_q > gbrm_pkg::FREQ_CFG_W'(gbrm_pkg::FREQ_MAX))
			eff_f_c = gbrm_pkg::FREQ_CFG_W'(gbrm_pkg::FREQ_MAX);
		else
			eff_f_c = freq_cfg_q;
		if (accel_cfg_q == '0)
			eff_a_c = gbrm_pkg::ACCEL_CFG_W'(1);
		else if (accel_cfg_q > gbrm_pkg::ACCEL_CFG_W'(gbrm_pkg::ACCEL_MAX))
			eff_a_c = gbrm_pkg::ACCEL_CFG_W'(gbrm_pkg::ACCEL_MAX);
		else
			eff_a_c = accel_cfg_q;
	end

	// ---------------------------------------------------------------- state
	gbrm_pkg::state_t state_q, state_d;

	logic [gbrm_pkg::FREQ_W-1:0]   f_lo_q, f_hi_q, f_hi_c;
	logic [gbrm_pkg::ACCEL_W-1:0]  a_lo_q, a_hi_q, a_hi_c, r_q;
	logic [FW-1:0]                 q_q;
	logic [FW-1:0]                 lo_q, hi_q, hi_clip;
	logic [gbrm_pkg::WIDX_W-1:0]   w_q;
	logic [AW-1:0]                 clr_q;
	logic [gbrm_pkg::MARKED_W-1:0] marked_q, marked_d;
	logic [gbrm_pkg::WINDOW_W-1:0] win_q;

	logic                          rsp_valid_q, keep_q;
	logic [gbrm_pkg::MARKED_W-1:0] cells_q;
	logic [gbrm_pkg::WINDOW_W-1:0] win_out_q;

	// mask RAM, one write and one read port, registered read
	gbrm_pkg::word_t mem [NWORDS];
	gbrm_pkg::word_t rdata_q, wr_data;
	logic            rd_en, wr_en;
	logic [AW-1:0]   rd_addr, wr_addr;

	logic            req_acc, out_free, out_load, keep_d, out_keep_d;
	logic            lo_ok, lo_beyond, q_in, row_last, word_last;
	logic [gbrm_pkg::NCELLS_W-1:0] row_base, span_lo, span_hi;
	logic [BW-1:0]   blo, bhi;
	gbrm_pkg::word_t span_mask, added;
	logic [BW:0]     pop;
	logic [gbrm_pkg::MARKED_W:0] marked_sum;

	assign req_acc  = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;

	// ------------------------------------------------------ rectangle setup
	assign lo_ok = (gbrm_pkg::FREQ_CFG_W'(f_lo_q) < eff_f_q)
		&& (gbrm_pkg::ACCEL_CFG_W'(a_lo_q) < eff_a_q);

	always_comb begin
		if (gbrm_pkg::FREQ_CFG_W'(f_hi_q) >= eff_f_q)
			f_hi_c = gbrm_pkg::FREQ_W'(eff_f_q - gbrm_pkg::FREQ_CFG_W'(1));
		else
			f_hi_c = f_hi_q;
		if (f_hi_c < f_lo_q)
			f_hi_c = f_lo_q;
		if (gbrm_pkg::ACCEL_CFG_W'(a_hi_q) >= eff_a_q)
			a_hi_c = gbrm_pkg::ACCEL_W'(eff_a_q - gbrm_pkg::ACCEL_CFG_W'(1));
		else
			a_hi_c = a_hi_q;
		if (a_hi_c < a_lo_q)
			a_hi_c = a_lo_q;
	end

	// row span in flat cell indices
	assign row_base = {{(gbrm_pkg::NCELLS_W - gbrm_pkg::ACCEL_W){1'b0}}, r_q}
		* {{(gbrm_pkg::NCELLS_W - gbrm_pkg::FREQ_CFG_W){1'b0}}, eff_f_q};
	assign span_lo = row_base + gbrm_pkg::NCELLS_W'(f_lo_q);
	assign span_hi = row_base + gbrm_pkg::NCELLS_W'(f_hi_q);

	// cells at MAX_CELLS and above are never stored
	assign lo_beyond = 32'(lo_q) >= MAX_CELLS;
	assign hi_clip   = (32'(hi_q) >= MAX_CELLS) ? FW'(MAX_CELLS - 1) : hi_q;

	assign row_last  = r_q == a_hi_q;
	assign word_last = w_q == hi_q[FW-1:BW];

	// ------------------------------------------------------ word merge
	assign blo = (w_q == lo_q[FW-1:BW]) ? lo_q[BW-1:0] : '0;
	assign bhi = word_last ? hi_q[BW-1:0] : BW'(WB - 1);
	assign span_mask = (gbrm_pkg::word_t'('1) << blo)
		& (gbrm_pkg::word_t'('1) >> (BW'(WB - 1) - bhi));
	assign added = span_mask & ~rdata_q;
	assign pop   = (BW + 1)'($countones(added));
	assign marked_sum = {1'b0, marked_q} + (gbrm_pkg::MARKED_W + 1)'(pop);
	assign marked_d = marked_sum[gbrm_pkg::MARKED_W] ? '1
		: marked_sum[gbrm_pkg::MARKED_W-1:0];

	// ------------------------------------------------------ query answer
	assign q_in   = (32'(q_q) < 32'(ncells_q)) && (32'(q_q) < MAX_CELLS);
	assign keep_d = q_in ? !rdata_q[q_q[BW-1:0]] : 1'b1;

	// ------------------------------------------------------ sequencer
	always_comb begin
		state_d    = state_q;
		req.ready  = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_data    = '0;
		out_load   = 1'b0;
		out_keep_d = 1'b0;
		case (state_q)
			gbrm_pkg::ST_INIT: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				if (clr_q == LAST_WORD)
					state_d = gbrm_pkg::ST_IDLE;
			end
			gbrm_pkg::ST_CLR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				if (clr_q == LAST_WORD)
					state_d = gbrm_pkg::ST_RESP;
			end
			gbrm_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					case (req.cmd)
						gbrm_pkg::CMD_CLEAR: state_d = gbrm_pkg::ST_CLR;
						gbrm_pkg::CMD_MARK:  state_d = gbrm_pkg::ST_MSETUP;
						gbrm_pkg::CMD_QUERY: begin
							rd_en   = 1'b1;
							rd_addr = AW'(req.query_cell[FW-1:BW]);
							state_d = gbrm_pkg::ST_QRES;
						end
						default: state_d = gbrm_pkg::ST_RESP;
					endcase
				end
			end
			gbrm_pkg::ST_MSETUP: begin
				state_d = lo_ok ? gbrm_pkg::ST_MROW : gbrm_pkg::ST_RESP;
			end
			gbrm_pkg::ST_MROW: begin
				state_d = gbrm_pkg::ST_MSPAN;
			end
			gbrm_pkg::ST_MSPAN: begin
				if (!lo_beyond)
					state_d = gbrm_pkg::ST_MRD;
				else if (row_last)
					state_d = gbrm_pkg::ST_RESP;
				else
					state_d = gbrm_pkg::ST_MROW;
			end
			gbrm_pkg::ST_MRD: begin
				rd_en   = 1'b1;
				rd_addr = AW'(w_q);
				state_d = gbrm_pkg::ST_MWR;
			end
			gbrm_pkg::ST_MWR: begin
				wr_en   = 1'b1;
				wr_addr = AW'(w_q);
				wr_data = rdata_q | span_mask;
				if (!word_last)
					state_d = gbrm_pkg::ST_MRD;
				else if (row_last)
					state_d = gbrm_pkg::ST_RESP;
				else
					state_d = gbrm_pkg::ST_MROW;
			end
			gbrm_pkg::ST_QRES: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_keep_d = keep_d;
					state_d    = gbrm_pkg::ST_IDLE;
				end
			end
			gbrm_pkg::ST_RESP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = gbrm_pkg::ST_IDLE;
				end
			end
			default: state_d = gbrm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= gbrm_pkg::ST_INIT;
		else
			state_q <= state_d;
	end

	// ------------------------------------------------------ control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_cfg_q  <= gbrm_pkg::FREQ_CFG_W'(gbrm_pkg::FREQ_MAX);
			accel_cfg_q <= gbrm_pkg::ACCEL_CFG_W'(gbrm_pkg::ACCEL_MAX);
			eff_f_q     <= gbrm_pkg::FREQ_CFG_W'(gbrm_pkg::FREQ_MAX);
			eff_a_q     <= gbrm_pkg::ACCEL_CFG_W'(gbrm_pkg::ACCEL_MAX);
			ncells_q    <= gbrm_pkg::NCELLS_W'(gbrm_pkg::FREQ_MAX * gbrm_pkg::ACCEL_MAX);
			clr_q       <= '0;
			marked_q    <= '0;
			win_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					gbrm_pkg::CFG_FREQ_CELLS:  freq_cfg_q <= cfg.data;
					gbrm_pkg::CFG_ACCEL_CELLS:
						accel_cfg_q <= cfg.data[gbrm_pkg::ACCEL_CFG_W-1:0];
					default: ;
				endcase
			end
			eff_f_q  <= eff_f_c;
			eff_a_q  <= eff_a_c;
			ncells_q <= {{(gbrm_pkg::NCELLS_W - gbrm_pkg::FREQ_CFG_W){1'b0}}, eff_f_c}
				* {{(gbrm_pkg::NCELLS_W - gbrm_pkg::ACCEL_CFG_W){1'b0}}, eff_a_c};

			if (state_q == gbrm_pkg::ST_INIT || state_q == gbrm_pkg::ST_CLR)
				clr_q <= (clr_q == LAST_WORD) ? '0 : clr_q + AW'(1);

			if (req_acc && req.cmd == gbrm_pkg::CMD_CLEAR) begin
				marked_q <= '0;
				win_q    <= '0;
			end
			if (state_q == gbrm_pkg::ST_MSETUP && lo_ok && win_q != '1)
				win_q <= win_q + gbrm_pkg::WINDOW_W'(1);
			if (state_q == gbrm_pkg::ST_MWR)
				marked_q <= marked_d;

			if (out_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// ------------------------------------------------------ payload registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			f_lo_q <= req.freq_lo;
			f_hi_q <= req.freq_hi;
			a_lo_q <= req.accel_lo;
			a_hi_q <= req.accel_hi;
			q_q    <= req.query_cell;
		end
		if (state_q == gbrm_pkg::ST_MSETUP) begin
			f_hi_q <= f_hi_c;
			a_hi_q <= a_hi_c;
			r_q    <= a_lo_q;
		end
		if (state_q == gbrm_pkg::ST_MROW) begin
			lo_q <= span_lo[FW-1:0];
			hi_q <= span_hi[FW-1:0];
		end
		if (state_q == gbrm_pkg::ST_MSPAN) begin
			hi_q <= hi_clip;
			w_q  <= lo_q[FW-1:BW];
			if (lo_beyond)
				r_q <= r_q + gbrm_pkg::ACCEL_W'(1);
		end
		if (state_q == gbrm_pkg::ST_MWR) begin
			w_q <= w_q + gbrm_pkg::WIDX_W'(1);
			if (word_last)
				r_q <= r_q + gbrm_pkg::ACCEL_W'(1);
		end
		if (out_load) begin
			keep_q    <= out_keep_d;
			cells_q   <= marked_q;
			win_out_q <= win_q;
		end
	end

	// ------------------------------------------------------ mask RAM
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rdata_q <= mem[rd_addr];
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.keep          = keep_q;
	assign rsp.cells_marked  = cells_q;
	assign rsp.windows_added = win_out_q;

	// ------------------------------------------------------ assertions
	a_query_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.cmd == gbrm_pkg::CMD_QUERY) |=> state_q == gbrm_pkg::ST_QRES)
		else $error("query not followed by its answer cycle");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> rd_addr != wr_addr)
		else $error("RAM read and write to one word in one cycle");

	a_marked_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_acc && req.cmd == gbrm_pkg::CMD_CLEAR) |=> marked_q >= $past(marked_q))
		else $error("marked count fell without a clear");

	a_window_steady: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != gbrm_pkg::ST_MSETUP && !(req_acc && req.cmd == gbrm_pkg::CMD_CLEAR))
		|=> win_q == $past(win_q))
		else $error("window count moved outside rectangle setup");

	a_word_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gbrm_pkg::ST_MRD |-> (w_q >= lo_q[FW-1:BW]) && (w_q <= hi_q[FW-1:BW]))
		else $error("word walk left the row span");

endmodule

// File: dv/grid_bitmap_rectangle_mask_check.sv
module grid_bitmap_rectangle_mask_check #(
	parameter int unsigned MAX_CELLS = gbrm_pkg::MAX_CELLS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	gbrm_cfg_if         cfg,
	gbrm_req_if         req,
	gbrm_rsp_if         rsp,
	output int unsigned mismatches,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import gbrm_pkg::*;

	localparam int unsigned NWORDS = (MAX_CELLS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned MARKED_SAT = (1 << MARKED_W) - 1;
	localparam int unsigned REPORT_MAX = 10;

	typedef struct packed {
		logic                keep;
		logic [MARKED_W-1:0] cells_marked;
		logic [WINDOW_W-1:0] windows_added;
	} result_t;

	// shadow of the block's state
	word_t                  mask_shadow [NWORDS];
	logic [MARKED_W-1:0]    marked_total;
	logic [WINDOW_W-1:0]    window_total;
	logic [FREQ_CFG_W-1:0]  freq_reg;
	logic [ACCEL_CFG_W-1:0] accel_reg;

	result_t     results_due [$];
	int unsigned fail_count;
	int unsigned results_seen;

	// set flat bits lo..hi, clipped at the end of the store
	function automatic void set_span(input int unsigned lo, input int unsigned hi);
		int unsigned w;
		int unsigned blo;
		int unsigned bhi;
		int unsigned sum;
		word_t bits;
		word_t added;
		if (lo >= MAX_CELLS)
			return;
		if (hi >= MAX_CELLS)
			hi = MAX_CELLS - 1;
		for (w = lo / WORD_BITS; w <= hi / WORD_BITS; w++) begin
			blo = (w == lo / WORD_BITS) ? lo % WORD_BITS : 0;
			bhi = (w == hi / WORD_BITS) ? hi % WORD_BITS : WORD_BITS - 1;
			bits = (word_t'('1) << blo) & (word_t'('1) >> (WORD_BITS - 1 - bhi));
			added = bits & ~mask_shadow[w];
			sum = marked_total + $countones(added);
			marked_total = (sum > MARKED_SAT) ? '1 : MARKED_W'(sum);
			mask_shadow[w] = mask_shadow[w] | bits;
		end
	endfunction

	function automatic result_t mask_outcome(input logic [CMD_W-1:0] op,
		input int unsigned flo, input int unsigned fhi,
		input int unsigned alo, input int unsigned ahi, input int unsigned flat);
		result_t res;
		int unsigned cols;
		int unsigned rows;
		int unsigned r;
		cols = (freq_reg == 0) ? 1 : (freq_reg > FREQ_MAX) ? FREQ_MAX : freq_reg;
		rows = (accel_reg == 0) ? 1 : (accel_reg > ACCEL_MAX) ? ACCEL_MAX : accel_reg;
		res.keep = 1'b0;
		case (op)
			CMD_CLEAR: begin
				foreach (mask_shadow[i])
					mask_shadow[i] = '0;
				marked_total = '0;
				window_total = '0;
			end
			CMD_MARK: begin
				// rectangle ignored when its low corner is off the grid
				if (flo < cols && alo < rows) begin
					if (fhi >= cols)
						fhi = cols - 1;
					if (ahi >= rows)
						ahi = rows - 1;
					if (fhi < flo)
						fhi = flo;
					if (ahi < alo)
						ahi = alo;
					for (r = alo; r <= ahi; r++)
						set_span(r * cols + flo, r * cols + fhi);
					if (window_total != '1)
						window_total = window_total + 1'b1;
				end
			end
			CMD_QUERY: begin
				if (flat >= cols * rows || flat >= MAX_CELLS)
					res.keep = 1'b1;
				else
					res.keep = ~mask_shadow[(flat / WORD_BITS) % NWORDS][flat % WORD_BITS];
			end
			default: ;
		endcase
		res.cells_marked = marked_total;
		res.windows_added = window_total;
		return res;
	endfunction

	function automatic void check_result();
		result_t want;
		result_t got;
		got.keep = rsp.keep;
		got.cells_marked = rsp.cells_marked;
		got.windows_added = rsp.windows_added;
		if (results_due.size() == 0) begin
			if (fail_count < REPORT_MAX)
				$display("%0t: result %0d with none due: keep %0b cells %0d windows %0d",
					$realtime, results_seen, got.keep, got.cells_marked, got.windows_added);
			fail_count++;
		end else begin
			want = results_due.pop_front();
			if (got.keep !== want.keep || got.cells_marked !== want.cells_marked
					|| got.windows_added !== want.windows_added) begin
				if (fail_count < REPORT_MAX)
					$display("%0t: result %0d wrong: keep %0b/%0b cells %0d/%0d windows %0d/%0d (exp/got)",
						$realtime, results_seen, want.keep, got.keep, want.cells_marked,
						got.cells_marked, want.windows_added, got.windows_added);
				fail_count++;
			end
		end
		results_seen++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (mask_shadow[i])
				mask_shadow[i] = '0;
			marked_total = '0;
			window_total = '0;
			freq_reg = FREQ_CFG_W'(FREQ_MAX);
			accel_reg = ACCEL_CFG_W'(ACCEL_MAX);
			results_due.delete();
			fail_count = 0;
			results_seen = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_FREQ_CELLS)
					freq_reg = cfg.data[FREQ_CFG_W-1:0];
				else
					accel_reg = cfg.data[ACCEL_CFG_W-1:0];
			end
			// results leave before the new beat is booked: a result can never
			// belong to the command taken on the same edge
			if (rsp.valid && rsp.ready)
				check_result();
			if (req.valid && req.ready)
				results_due.push_back(mask_outcome(req.cmd, req.freq_lo, req.freq_hi,
					req.accel_lo, req.accel_hi, req.query_cell));
			mismatches <= fail_count;
			outstanding <= results_due.size();
		end
	end

endmodule

// File: dv/grid_bitmap_rectangle_mask_tb.sv
module grid_bitmap_rectangle_mask_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gbrm_pkg::*;

	// cmd value with no operation behind it
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// idle-free stretch limit; the slowest steps are a full-grid mark and the
	// clearing pass after reset
	localparam int unsigned WATCHDOG_LIMIT = 40000;
	localparam int unsigned RANDOM_PHASES = 8;
	localparam int unsigned BEATS_PER_PHASE = 85;
	localparam int unsigned PRESSURE_BEATS = 40;
	localparam int unsigned HOLD_CYCLES = 600;
	localparam int unsigned SETTLE_CYCLES = 16;

	logic clk = 1'b0;
	logic arst_n;

	gbrm_cfg_if cfg_ch ();
	gbrm_req_if req_ch ();
	gbrm_rsp_if rsp_ch ();

	int unsigned mismatches;
	int unsigned outstanding;

	// traffic shaping; the idle and stall rates change only between phases
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic        hold_off;
	int unsigned quiet_cycles;

	// effective grid as the block sees it, for aiming the stimulus
	int unsigned cols = FREQ_MAX;
	int unsigned rows = ACCEL_MAX;

	// last rectangle that stuck, clamped; queries are aimed around it
	int unsigned rect_flo = 0;
	int unsigned rect_fhi = 0;
	int unsigned rect_alo = 0;
	int unsigned rect_ahi = 0;

	int unsigned phase;

	grid_bitmap_rectangle_mask dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	grid_bitmap_rectangle_mask_check mask_watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_ch),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// result side: random stalls, plus the long hold-off while hold_off is up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog: any beat on any channel counts as progress
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// 0: no idling, 1: sender gaps, 2: receiver stalls, 3: both
	task automatic set_mode(input int unsigned mode);
		case (mode)
			0: begin
				send_idle_pct <= 0;
				recv_stall_pct <= 0;
			end
			1: begin
				send_idle_pct <= 45;
				recv_stall_pct <= 0;
			end
			2: begin
				send_idle_pct <= 0;
				recv_stall_pct <= 45;
			end
			default: begin
				send_idle_pct <= 27;
				recv_stall_pct <= 27;
			end
		endcase
	endtask

	// one command beat; returns on the edge that takes it
	task automatic send_beat(input logic [CMD_W-1:0] op, input int unsigned flo,
		input int unsigned fhi, input int unsigned alo, input int unsigned ahi,
		input int unsigned flat);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= op;
		req_ch.freq_lo <= FREQ_W'(flo);
		req_ch.freq_hi <= FREQ_W'(fhi);
		req_ch.accel_lo <= ACCEL_W'(alo);
		req_ch.accel_hi <= ACCEL_W'(ahi);
		req_ch.query_cell <= FLAT_W'(flat);
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// stop offering and wait until every booked result is back; the count is
	// updated on the edge, so it is read only after the edge has passed
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both registers back to back; only ever called with the block idle
	task automatic set_grid(input int unsigned fval, input int unsigned aval);
		int unsigned fv;
		int unsigned av;
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_FREQ_CELLS;
		cfg_ch.data <= CFG_DATA_W'(fval);
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.index <= CFG_ACCEL_CELLS;
		cfg_ch.data <= CFG_DATA_W'(aval);
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		// zero reads as one, oversize reads as the ceiling
		fv = fval % (1 << FREQ_CFG_W);
		av = aval % (1 << ACCEL_CFG_W);
		cols = (fv == 0) ? 1 : (fv > FREQ_MAX) ? FREQ_MAX : fv;
		rows = (av == 0) ? 1 : (av > ACCEL_MAX) ? ACCEL_MAX : av;
	endtask

	task automatic note_rect(input int unsigned f0, input int unsigned f1,
		input int unsigned a0, input int unsigned a1);
		if (f0 < cols && a0 < rows) begin
			rect_flo = f0;
			rect_alo = a0;
			rect_fhi = (f1 >= cols) ? cols - 1 : f1;
			rect_ahi = (a1 >= rows) ? rows - 1 : a1;
			if (rect_fhi < f0)
				rect_fhi = f0;
			if (rect_ahi < a0)
				rect_ahi = a0;
		end
	endtask

	// mostly queries, marks now and then, rare clears and unused commands;
	// most marks are kept small so that the grid walk stays short
	task automatic random_beat();
		int unsigned pick;
		int unsigned f0;
		int unsigned f1;
		int unsigned a0;
		int unsigned a1;
		int unsigned flat;
		int unsigned r;
		int unsigned c;
		pick = $urandom_range(99);
		f0 = $urandom_range(FREQ_MAX - 1);
		f1 = $urandom_range(FREQ_MAX - 1);
		a0 = $urandom_range(ACCEL_MAX - 1);
		a1 = $urandom_range(ACCEL_MAX - 1);
		flat = $urandom_range((1 << FLAT_W) - 1);
		if (pick < 3) begin
			send_beat(CMD_CLEAR, f0, f1, a0, a1, flat);
		end else if (pick < 6) begin
			send_beat(CMD_UNUSED, f0, f1, a0, a1, flat);
		end else if (pick < 20) begin
			case ($urandom_range(19))
				0: begin
					// low corner off the grid, where the grid leaves room
					if (cols < FREQ_MAX)
						f0 = $urandom_range(FREQ_MAX - 1, cols);
					else if (rows < ACCEL_MAX)
						a0 = $urandom_range(ACCEL_MAX - 1, rows);
				end
				1: begin
					// wide: high bounds left random, clamped by the block
					f0 = $urandom_range(cols - 1);
					a0 = $urandom_range(rows - 1);
				end
				2: begin
					// high bounds at or below the low ones
					f0 = $urandom_range(cols - 1);
					a0 = $urandom_range(rows - 1);
					f1 = $urandom_range(f0);
					a1 = $urandom_range(a0);
				end
				default: begin
					f0 = $urandom_range(cols - 1);
					a0 = $urandom_range(rows - 1);
					f1 = (f0 + $urandom_range(70)) % FREQ_MAX;
					a1 = (a0 + $urandom_range(3)) % ACCEL_MAX;
				end
			endcase
			note_rect(f0, f1, a0, a1);
			send_beat(CMD_MARK, f0, f1, a0, a1, flat);
		end else begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				// around the last rectangle, one column beyond each side edge, rows within it
				r = $urandom_range(rect_ahi, rect_alo);
				c = $urandom_range(rect_fhi + 1, (rect_flo == 0) ? 0 : rect_flo - 1);
				if (r >= rows)
					r = rows - 1;
				if (c >= cols)
					c = cols - 1;
				flat = r * cols + c;
			end else if (pick < 85) begin
				flat = $urandom_range(cols * rows - 1);
			end
			send_beat(CMD_QUERY, f0, f1, a0, a1, flat);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		hold_off <= 1'b0;
		send_idle_pct <= 0;
		recv_stall_pct <= 0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_CLEAR;
		req_ch.freq_lo <= '0;
		req_ch.freq_hi <= '0;
		req_ch.accel_lo <= '0;
		req_ch.accel_hi <= '0;
		req_ch.query_cell <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_FREQ_CELLS;
		cfg_ch.data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed, on the reset grid of 1024 x 256
		send_beat(CMD_QUERY, 0, 0, 0, 0, 0);
		send_beat(CMD_QUERY, 0, 0, 0, 0, 262143);
		send_beat(CMD_MARK, 0, 1023, 0, 255, 0);          // whole grid, longest walk
		send_beat(CMD_QUERY, 0, 0, 0, 0, 262143);
		send_beat(CMD_UNUSED, 1023, 1023, 255, 255, 262143);
		send_beat(CMD_CLEAR, 1023, 1023, 255, 255, 262143);
		send_beat(CMD_QUERY, 0, 0, 0, 0, 0);
		send_beat(CMD_MARK, 1023, 1023, 255, 255, 0);     // far corner cell
		send_beat(CMD_MARK, 500, 3, 10, 2, 0);            // highs below lows
		send_beat(CMD_MARK, 60, 70, 1, 3, 0);             // crosses a word edge
		send_beat(CMD_QUERY, 0, 0, 0, 0, 10 * 1024 + 500);
		send_beat(CMD_QUERY, 0, 0, 0, 0, 10 * 1024 + 501);
		send_beat(CMD_QUERY, 0, 0, 0, 0, 1 * 1024 + 64);
		drain();

		// zero registers read as a 1 x 1 grid
		set_grid(0, 0);
		send_beat(CMD_QUERY, 0, 0, 0, 0, 0);
		send_beat(CMD_QUERY, 0, 0, 0, 0, 1);              // off the grid
		send_beat(CMD_MARK, 1, 5, 0, 0, 0);               // column off the grid
		send_beat(CMD_MARK, 0, 0, 1, 0, 0);               // row off the grid
		send_beat(CMD_MARK, 0, 1023, 0, 255, 0);          // clamped to one cell
		send_beat(CMD_QUERY, 0, 0, 0, 0, 0);
		drain();

		// every register bit set: oversize values fall back to the ceiling
		set_grid(2047, 511);
		send_beat(CMD_MARK, 0, 1023, 254, 255, 0);
		send_beat(CMD_QUERY, 0, 0, 0, 0, 255 * 1024);
		drain();

		// odd width, oversize rows: grid of 37 x 256
		set_grid(37, 300);
		send_beat(CMD_QUERY, 0, 0, 0, 0, 9471);
		send_beat(CMD_QUERY, 0, 0, 0, 0, 9472);           // first cell past the grid
		send_beat(CMD_MARK, 36, 40, 255, 255, 0);
		send_beat(CMD_QUERY, 0, 0, 0, 0, 9471);

		// random phases, cycling through the idling modes and grid shapes
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain();
			case (phase)
				0: set_grid(1024, 256);
				1: set_grid(1, 1);
				2: set_grid(64, 4);
				3: set_grid($urandom_range(2047), $urandom_range(2047));
				4: set_grid(1024, 1);
				5: set_grid(1, 256);
				6: set_grid($urandom_range(1024, 1), $urandom_range(256, 1));
				default: set_grid(1000, 200);
			endcase
			set_mode(phase % 4);
			if (phase == 0) begin
				// result side shut for a long stretch while beats keep coming,
				// so the block backs up and drops its ready
				fork
					begin
						hold_off <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_off <= 1'b0;
					end
					repeat (PRESSURE_BEATS) random_beat();
				join
			end
			repeat (BEATS_PER_PHASE) random_beat();
		end

		// short closing run on a single-cell grid
		drain();
		set_grid(1, 1);
		set_mode(0);
		send_beat(CMD_MARK, 0, 1023, 0, 255, 0);
		send_beat(CMD_QUERY, 0, 0, 0, 0, 0);
		send_beat(CMD_UNUSED, 0, 0, 0, 0, 0);
		send_beat(CMD_CLEAR, 0, 0, 0, 0, 0);
		send_beat(CMD_QUERY, 0, 0, 0, 0, 0);
		drain();

		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
